/* rtl/kmer_d2_counter_assert.svh */
// assertion macros for the k-mer d2 counter
`ifndef KMER_D2_COUNTER_ASSERT_SVH
`define KMER_D2_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KD2_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define KD2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kd2_pkg.sv */
`timescale 1ns / 1ps
package kd2_pkg;

  localparam int LETTER_BITS = 2;
  localparam int MAX_WORD    = 8;
  localparam int STORE_BITS  = LETTER_BITS * MAX_WORD;
  localparam int COUNT_W     = 32;
  localparam int WLEN_W      = 4;
  localparam int FILL_W      = $clog2(MAX_WORD + 1);
  localparam int WLEN_RESET  = 8;

  typedef enum logic [1:0] {
    ACT_QUERY    = 2'd0,
    ACT_SUBJECT  = 2'd1,
    ACT_CLR_SUBJ = 2'd2,
    ACT_CLR_ALL  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic                  hit;
    logic [STORE_BITS-1:0] idx;
  } word_t;

endpackage

/* rtl/kd2_ram.sv */
`timescale 1ns / 1ps
module kd2_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/kd2_window.sv */
`timescale 1ns / 1ps
module kd2_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        seq_start,
  input  logic [1:0]                  letter,
  input  logic [kd2_pkg::WLEN_W-1:0]  word_length,
  output kd2_pkg::word_t              word
);
  import kd2_pkg::*;

  logic [STORE_BITS-1:0]  window_r, window_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [STORE_BITS-1:0]  win_base;
  logic [FILL_W-1:0]      fill_base;
  logic [LETTER_BITS-1:0] lt;
  logic [WLEN_W-1:0]      k;
  logic [STORE_BITS-1:0]  idx;

  // clamp word length into 1..MAX_WORD
  always_comb begin
    if (word_length == '0) begin
      k = WLEN_W'(1);
    end else if (word_length > WLEN_W'(MAX_WORD)) begin
      k = WLEN_W'(MAX_WORD);
    end else begin
      k = word_length;
    end
  end

  always_comb begin
    lt        = LETTER_BITS'(letter);
    win_base  = seq_start ? '0 : window_r;
    fill_base = seq_start ? '0 : fill_r;
    if (STORE_BITS > LETTER_BITS) begin
      window_nxt = STORE_BITS'({win_base, lt});
    end else begin
      window_nxt = STORE_BITS'(lt);
    end
    fill_nxt = (fill_base < FILL_W'(MAX_WORD)) ? fill_base + FILL_W'(1) : fill_base;
  end

  // keep only the low k letters of the window
  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (WLEN_W'(i) < k) begin
        idx[i*LETTER_BITS +: LETTER_BITS] = window_nxt[i*LETTER_BITS +: LETTER_BITS];
      end
    end
  end

  assign word.hit = (WLEN_W'(fill_nxt) >= k);
  assign word.idx = idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
    end else if (step) begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

/* rtl/kmer_d2_counter.sv */
`timescale 1ns / 1ps
// k-mer word counter with running D2 statistic. A query or subject letter
// takes two steps: a read of its word's counts from the two count memories
// (one registered read port each), then, once the output is free, update,
// write back and load of the result register; the next item is taken once
// the result is loaded, even if it has not yet been taken downstream. A
// clear action walks all 65536 subject memory entries (the query ones too
// for a clear-all) one entry per cycle, then gives its result via the
// update state. After reset both memories get this pass before any item;
// word_length writes are taken at any time but belong between items.
module kmer_d2_counter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [1:0]                     in_letter,
  input  logic                           in_seq_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_d2_total,
  output logic                           out_word_formed,
  output logic [31:0]                    out_word_query_count,
  output logic [31:0]                    out_word_subject_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kd2_pkg::WLEN_W-1:0]     cfg_word_length
);
  import kd2_pkg::*;

`include "kmer_d2_counter_assert.svh"

  state_t                state_r, state_nxt;
  action_t               op_r;
  action_t               in_act;
  logic                  hit_r;
  logic [STORE_BITS-1:0] idx_r;
  logic [STORE_BITS-1:0] sweep_addr_r;
  logic                  sweep_all_r;
  logic                  emit_r;
  logic [COUNT_W-1:0]    d2_r, d2_nxt;
  logic [WLEN_W-1:0]     wlen_r;

  logic                  out_valid_r;
  logic [COUNT_W-1:0]    out_d2_r;
  logic                  out_formed_r;
  logic [COUNT_W-1:0]    out_qc_r;
  logic [COUNT_W-1:0]    out_sc_r;

  logic                  accept_in;
  logic                  is_letter;
  logic                  out_free;
  logic                  out_load;
  logic                  sweep_last;
  word_t                 word;

  logic                  rd_en;
  logic                  q_we, s_we;
  logic [STORE_BITS-1:0] waddr;
  logic [COUNT_W-1:0]    q_wdata, s_wdata;
  logic [COUNT_W-1:0]    q_cur, s_cur;
  logic [COUNT_W-1:0]    q_upd, s_upd;
  logic                  formed;

  assign in_act     = action_t'(in_action);
  assign is_letter  = (in_act == ACT_QUERY) || (in_act == ACT_SUBJECT);
  assign accept_in  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign sweep_last = (sweep_addr_r == '1);
  assign cfg_ready  = 1'b1;

  kd2_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept_in && is_letter),
    .seq_start   (in_seq_start),
    .letter      (in_letter),
    .word_length (wlen_r),
    .word        (word)
  );

  kd2_ram #(.ADDR_W(STORE_BITS), .DATA_W(COUNT_W)) u_query_mem (
    .clk   (clk),
    .we    (q_we),
    .waddr (waddr),
    .wdata (q_wdata),
    .re    (rd_en),
    .raddr (word.idx),
    .rdata (q_cur)
  );

  kd2_ram #(.ADDR_W(STORE_BITS), .DATA_W(COUNT_W)) u_subject_mem (
    .clk   (clk),
    .we    (s_we),
    .waddr (waddr),
    .wdata (s_wdata),
    .re    (rd_en),
    .raddr (word.idx),
    .rdata (s_cur)
  );

  // count update from the read data
  always_comb begin
    formed = 1'b0;
    q_upd  = q_cur;
    s_upd  = s_cur;
    d2_nxt = d2_r;
    if (hit_r) begin
      case (op_r)
        ACT_QUERY: begin
          formed = 1'b1;
          q_upd  = q_cur + COUNT_W'(1);
          d2_nxt = d2_r + s_cur;
        end
        ACT_SUBJECT: begin
          if (q_cur != '0) begin
            formed = 1'b1;
            s_upd  = s_cur + COUNT_W'(1);
            d2_nxt = d2_r + q_cur;
          end
        end
        default: begin
          formed = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          state_nxt = is_letter ? ST_UPDATE : ST_SWEEP;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = emit_r ? ST_UPDATE : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    q_we     = 1'b0;
    s_we     = 1'b0;
    out_load = 1'b0;
    waddr    = idx_r;
    q_wdata  = q_upd;
    s_wdata  = s_upd;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid && is_letter;
      end
      ST_UPDATE: begin
        out_load = out_free;
        q_we     = out_free && formed && (op_r == ACT_QUERY);
        s_we     = out_free && formed && (op_r == ACT_SUBJECT);
      end
      ST_SWEEP: begin
        waddr   = sweep_addr_r;
        q_wdata = '0;
        s_wdata = '0;
        q_we    = sweep_all_r;
        s_we    = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      op_r         <= ACT_CLR_ALL;
      hit_r        <= 1'b0;
      sweep_addr_r <= '0;
      sweep_all_r  <= 1'b1;
      emit_r       <= 1'b0;
      d2_r         <= '0;
      wlen_r       <= WLEN_W'(WLEN_RESET);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        wlen_r <= cfg_word_length;
      end
      if (accept_in) begin
        op_r  <= in_act;
        hit_r <= word.hit && is_letter;
        if (!is_letter) begin
          d2_r         <= '0;
          sweep_addr_r <= '0;
          sweep_all_r  <= (in_act == ACT_CLR_ALL);
          emit_r       <= 1'b1;
        end
      end
      if (state_r == ST_SWEEP) begin
        sweep_addr_r <= sweep_addr_r + STORE_BITS'(1);
      end
      if (out_load) begin
        d2_r        <= d2_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      idx_r <= word.idx;
    end
    if (out_load) begin
      out_d2_r     <= d2_nxt;
      out_formed_r <= formed;
      out_qc_r     <= formed ? q_upd : '0;
      out_sc_r     <= formed ? s_upd : '0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_d2_total           = out_d2_r;
  assign out_word_formed        = out_formed_r;
  assign out_word_query_count   = out_qc_r;
  assign out_word_subject_count = out_sc_r;

  `KD2_ASSERT_NEXT(a_accept_leaves_idle, accept_in, (state_r == ST_UPDATE) || (state_r == ST_SWEEP), "accepted item did not start work")
  `KD2_ASSERT_SAME(a_query_write_src, q_we, ((state_r == ST_SWEEP) && sweep_all_r) || ((state_r == ST_UPDATE) && (op_r == ACT_QUERY)), "unexpected query memory write")
  `KD2_ASSERT_SAME(a_result_from_update, $rose(out_valid_r), $past(state_r) == ST_UPDATE, "result loaded outside update")
  `KD2_ASSERT_SAME(a_unformed_zero, out_valid_r && !out_formed_r, (out_qc_r == '0) && (out_sc_r == '0), "counts shown for unformed word")

endmodule
